// ===== src/ssrq_pkg.sv =====
// Shared types and constants for the sorted sector request queue.
`timescale 1ns / 1ps
package ssrq_pkg;

  localparam int DEPTH        = 16;
  localparam int TAG_WIDTH    = 8;
  localparam int SECTOR_WIDTH = 48;
  localparam int CNT_WIDTH    = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_REMOVE   = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [TAG_WIDTH-1:0]    tag;
    logic [SECTOR_WIDTH-1:0] sector;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                    capture;   // latch compare flags against the new command
    logic                    shift_en;  // apply the registered command to the row
    cmd_e                    cmd;       // registered command
    logic [TAG_WIDTH-1:0]    cap_tag;   // tag of the command being accepted
    logic [SECTOR_WIDTH-1:0] cap_sector;
    entry_t                  new_entry; // registered entry for an insert
  } bcast_t;

endpackage

// ===== src/ssrq_cell.sv =====
// One slot of the sorted queue: holds an entry and its compare flags.
`timescale 1ns / 1ps
module ssrq_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssrq_pkg::bcast_t               bc_i,
  input  logic                           occ_i,
  input  ssrq_pkg::entry_t               left_i,
  input  ssrq_pkg::entry_t               right_i,
  input  logic                           after_i,
  input  logic                           seen_i,
  input  logic                           first_left_i,
  input  logic                           first_right_i,
  input  logic [ssrq_pkg::TAG_WIDTH-1:0] prev_acc_i,
  input  logic [ssrq_pkg::TAG_WIDTH-1:0] next_acc_i,
  input  logic                           next_hit_i,
  output ssrq_pkg::entry_t               entry_o,
  output logic                           after_o,
  output logic                           seen_o,
  output logic                           first_o,
  output logic [ssrq_pkg::TAG_WIDTH-1:0] prev_acc_o,
  output logic [ssrq_pkg::TAG_WIDTH-1:0] next_acc_o,
  output logic                           next_hit_o
);
  import ssrq_pkg::*;

  entry_t entry_q, entry_d;
  logic   ge_q, match_q;
  logic   hit;
  logic   next_mine;

  // Latch compares while the row is still stable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ge_q    <= 1'b0;
      match_q <= 1'b0;
    end else if (bc_i.capture) begin
      ge_q    <= (entry_q.sector >= bc_i.cap_sector);
      match_q <= (entry_q.tag == bc_i.cap_tag);
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign hit       = occ_i && match_q;
  assign after_o   = !occ_i || ge_q;
  assign seen_o    = seen_i || hit;
  assign first_o   = hit && !seen_i;
  assign next_mine = first_left_i && occ_i;

  assign prev_acc_o = prev_acc_i | (first_right_i ? entry_q.tag : '0);
  assign next_acc_o = next_acc_i | (next_mine ? entry_q.tag : '0);
  assign next_hit_o = next_hit_i || next_mine;
  assign entry_o    = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (bc_i.shift_en) begin
      case (bc_i.cmd)
        CMD_INSERT: begin
          if (after_o) begin
            entry_d = after_i ? left_i : bc_i.new_entry;
          end
        end
        CMD_DISPATCH: begin
          entry_d = right_i;
        end
        CMD_REMOVE: begin
          if (seen_o) begin
            entry_d = right_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/sorted_sector_request_queue.sv =====
// Top level of the sorted sector request queue: controller and row of cells.
`timescale 1ns / 1ps
// Disk request queue kept in ascending sector order, slot 0 lowest.
// Command channel: cmd_i, req_tag_i and sector_i transfer at a rising edge
// where start is high and busy is low. Commands: insert (before the first
// entry whose sector is >= the new one, else at the tail), dispatch the
// lowest entry, remove by tag, and query the neighbors of a tag.
// A command is accepted and then applied. In the accept cycle every cell
// compares its entry with the incoming tag and sector and latches the
// flags; in the next cycle busy is high while the flags ripple along the
// cell row, entries shift toward their neighbors and the result is
// registered. valid_o strobes for exactly one cycle with the result, in
// the cycle after busy; a new command can transfer in that same cycle,
// but none while busy is high. The receiver cannot stall: the result must
// be taken in its strobe cycle.
// Reset clears the fill count, the pending flag and the strobe; the slot
// contents stay undefined and are never read until written.
// An insert into a full queue reports full, a dispatch on an empty queue
// reports empty, and a missing tag reports not found; none of those
// changes the queue.
module sorted_sector_request_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        cmd_i,
  input  logic [ssrq_pkg::TAG_WIDTH-1:0]    req_tag_i,
  input  logic [ssrq_pkg::SECTOR_WIDTH-1:0] sector_i,
  output logic                              valid_o,
  output logic [1:0]                        status_o,
  output logic [ssrq_pkg::TAG_WIDTH-1:0]    out_tag_o,
  output logic [ssrq_pkg::SECTOR_WIDTH-1:0] out_sector_o,
  output logic                              has_prev_o,
  output logic [ssrq_pkg::TAG_WIDTH-1:0]    prev_tag_o,
  output logic                              has_next_o,
  output logic [ssrq_pkg::TAG_WIDTH-1:0]    next_tag_o,
  output logic [ssrq_pkg::CNT_WIDTH-1:0]    fill_count_o
);
  import ssrq_pkg::*;

  logic                 pend_q;
  cmd_e                 cmd_q;
  entry_t               new_q;
  logic [CNT_WIDTH-1:0] count_q, count_d;
  logic                 accept;
  logic                 full, empty, found, ok;
  bcast_t               bc;

  // Row wiring.
  entry_t               ent_w      [DEPTH];
  logic                 after_w    [DEPTH];
  logic                 seen_w     [DEPTH];
  logic                 first_w    [DEPTH];
  logic [TAG_WIDTH-1:0] prev_acc_w [DEPTH];
  logic [TAG_WIDTH-1:0] next_acc_w [DEPTH];
  logic                 next_hit_w [DEPTH];
  logic                 occ        [DEPTH];

  // Result registers.
  logic                    valid_q;
  status_e                 status_q, status_d;
  logic [TAG_WIDTH-1:0]    out_tag_q, out_tag_d;
  logic [SECTOR_WIDTH-1:0] out_sec_q, out_sec_d;
  logic                    has_prev_q, has_prev_d;
  logic [TAG_WIDTH-1:0]    prev_tag_q, prev_tag_d;
  logic                    has_next_q, has_next_d;
  logic [TAG_WIDTH-1:0]    next_tag_q, next_tag_d;

  assign accept = start && !pend_q;
  assign busy   = pend_q;

  // Hold the accepted command for the apply cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
      count_q <= '0;
      cmd_q   <= CMD_INSERT;
    end else begin
      pend_q  <= accept;
      valid_q <= pend_q;
      count_q <= count_d;
      if (accept) begin
        cmd_q <= cmd_e'(cmd_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      new_q.tag    <= req_tag_i;
      new_q.sector <= sector_i;
    end
    if (pend_q) begin
      status_q   <= status_d;
      out_tag_q  <= out_tag_d;
      out_sec_q  <= out_sec_d;
      has_prev_q <= has_prev_d;
      prev_tag_q <= prev_tag_d;
      has_next_q <= has_next_d;
      next_tag_q <= next_tag_d;
    end
  end

  assign full  = (count_q == CNT_WIDTH'(DEPTH));
  assign empty = (count_q == '0);
  assign found = seen_w[DEPTH-1];

  always_comb begin
    case (cmd_q)
      CMD_INSERT:   ok = !full;
      CMD_DISPATCH: ok = !empty;
      CMD_REMOVE:   ok = found;
      default:      ok = 1'b0;
    endcase
  end

  assign bc.capture    = accept;
  assign bc.shift_en   = pend_q && ok;
  assign bc.cmd        = cmd_q;
  assign bc.cap_tag    = req_tag_i;
  assign bc.cap_sector = sector_i;
  assign bc.new_entry  = new_q;

  // Build the row; flags ripple left to right, entries move either way.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t               left_e, right_e;
    logic                 after_in, seen_in, first_l, first_r, next_hit_in;
    logic [TAG_WIDTH-1:0] prev_in, next_in;

    assign occ[i] = (CNT_WIDTH'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_e      = '0;
      assign after_in    = 1'b0;
      assign seen_in     = 1'b0;
      assign first_l     = 1'b0;
      assign prev_in     = '0;
      assign next_in     = '0;
      assign next_hit_in = 1'b0;
    end else begin : g_mid
      assign left_e      = ent_w[i-1];
      assign after_in    = after_w[i-1];
      assign seen_in     = seen_w[i-1];
      assign first_l     = first_w[i-1];
      assign prev_in     = prev_acc_w[i-1];
      assign next_in     = next_acc_w[i-1];
      assign next_hit_in = next_hit_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
      assign first_r = 1'b0;
    end else begin : g_body
      assign right_e = ent_w[i+1];
      assign first_r = first_w[i+1];
    end

    ssrq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .bc_i          (bc),
      .occ_i         (occ[i]),
      .left_i        (left_e),
      .right_i       (right_e),
      .after_i       (after_in),
      .seen_i        (seen_in),
      .first_left_i  (first_l),
      .first_right_i (first_r),
      .prev_acc_i    (prev_in),
      .next_acc_i    (next_in),
      .next_hit_i    (next_hit_in),
      .entry_o       (ent_w[i]),
      .after_o       (after_w[i]),
      .seen_o        (seen_w[i]),
      .first_o       (first_w[i]),
      .prev_acc_o    (prev_acc_w[i]),
      .next_acc_o    (next_acc_w[i]),
      .next_hit_o    (next_hit_w[i])
    );
  end

  // Fill count and result of the command in the apply cycle.
  always_comb begin
    count_d    = count_q;
    status_d   = ST_DONE;
    out_tag_d  = '0;
    out_sec_d  = '0;
    has_prev_d = 1'b0;
    prev_tag_d = '0;
    has_next_d = 1'b0;
    next_tag_d = '0;
    case (cmd_q)
      CMD_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (pend_q) begin
          count_d = count_q + CNT_WIDTH'(1);
        end
      end
      CMD_DISPATCH: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          out_tag_d = ent_w[0].tag;
          out_sec_d = ent_w[0].sector;
          if (pend_q) begin
            count_d = count_q - CNT_WIDTH'(1);
          end
        end
      end
      CMD_REMOVE: begin
        if (!found) begin
          status_d = ST_NOTFOUND;
        end else if (pend_q) begin
          count_d = count_q - CNT_WIDTH'(1);
        end
      end
      default: begin
        if (!found) begin
          status_d = ST_NOTFOUND;
        end else begin
          has_prev_d = !first_w[0];
          prev_tag_d = prev_acc_w[DEPTH-1];
          has_next_d = next_hit_w[DEPTH-1];
          next_tag_d = next_acc_w[DEPTH-1];
        end
      end
    endcase
  end

  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign out_tag_o    = out_tag_q;
  assign out_sector_o = out_sec_q;
  assign has_prev_o   = has_prev_q;
  assign prev_tag_o   = prev_tag_q;
  assign has_next_o   = has_next_q;
  assign next_tag_o   = next_tag_q;
  assign fill_count_o = count_q;

  // The apply cycle is always followed by a cycle with busy low and the result strobe.
  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (!busy && valid_o))
    else $error("busy did not end with a result strobe");

  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result strobe without a preceding apply cycle");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_WIDTH'(DEPTH))
    else $error("fill count beyond depth");

  a_full_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_FULL) |-> (fill_count_o == CNT_WIDTH'(DEPTH)))
    else $error("full status with room left");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(busy) |-> $stable(count_q))
    else $error("fill count changed outside the apply cycle");

endmodule
